>>> design/assert_macros.svh
// Assertion macros used by g128_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/g128_pkg.sv
// ----------------------------------------------------------------------------
// g128_pkg
// Types, codes and the round function shared by the Grain-128AEAD engine.
// ----------------------------------------------------------------------------
`default_nettype none
package g128_pkg;

  typedef enum logic [1:0] {
    REQ_AD     = 2'd0,
    REQ_MSG    = 2'd1,
    REQ_FINISH = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    CFG_KEY_LOW    = 3'd0,
    CFG_KEY_HIGH   = 3'd1,
    CFG_NONCE_LOW  = 3'd2,
    CFG_NONCE_HIGH = 3'd3,
    CFG_DECRYPT    = 3'd4
  } cfg_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_MIX  = 2'd1,
    PH_ACC  = 2'd2,
    PH_SR   = 2'd3
  } phase_e;

  localparam int unsigned BitsPerCycle = 16;
  localparam int unsigned MixCycles    = 256 / BitsPerCycle;
  localparam int unsigned LoadCycles   = 64 / BitsPerCycle;
  localparam int unsigned CntW         = 4;

  typedef struct packed {
    req_e       req;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic [127:0] lfsr;
    logic [127:0] nfsr;
  } cipher_t;

  typedef struct packed {
    cipher_t     st;
    logic [15:0] y;
  } step_t;

  // Advance the cipher 16 steps. feed_y adds y to both feedbacks, extra
  // carries one bit per step into the LFSR feedback.
  function automatic step_t grain_step16(cipher_t s, logic feed_y, logic [15:0] extra);
    logic [127:0] l;
    logic [127:0] n;
    logic         y;
    logic         fl;
    logic         gn;
    step_t        r;
    l = s.lfsr;
    n = s.nfsr;
    r.y = '0;
    for (int i = 0; i < 16; i++) begin
      y = n[2] ^ n[15] ^ n[36] ^ n[45] ^ n[64] ^ n[73] ^ n[89] ^ l[93]
        ^ (n[12] & l[8]) ^ (l[13] & l[20]) ^ (n[95] & l[42])
        ^ (l[60] & l[79]) ^ (n[12] & n[95] & l[94]);
      fl = l[0] ^ l[7] ^ l[38] ^ l[70] ^ l[81] ^ l[96];
      gn = l[0] ^ n[0] ^ n[26] ^ n[56] ^ n[91] ^ n[96]
         ^ (n[3] & n[67]) ^ (n[11] & n[13]) ^ (n[17] & n[18])
         ^ (n[27] & n[59]) ^ (n[40] & n[48]) ^ (n[61] & n[65])
         ^ (n[68] & n[84]) ^ (n[88] & n[92] & n[93] & n[95])
         ^ (n[22] & n[24] & n[25]) ^ (n[70] & n[78] & n[82]);
      fl = fl ^ (feed_y & y) ^ extra[i];
      gn = gn ^ (feed_y & y);
      l = {fl, l[127:1]};
      n = {gn, n[127:1]};
      r.y[i] = y;
    end
    r.st.lfsr = l;
    r.st.nfsr = n;
    return r;
  endfunction

endpackage
`default_nettype wire

>>> design/grain128_aead_byte_engine.sv
// ----------------------------------------------------------------------------
// grain128_aead_byte_engine
// Grain-128AEAD authenticated encryption, one byte per request.
// ----------------------------------------------------------------------------
// Requests enter through push/full with req_type_i (AD, message, finish) and
// data_byte_i. Results leave through empty/pop: message requests yield one
// out_byte_o, finish yields tag_o with is_tag_o set, AD yields nothing.
// Keys, nonce and mode go through the cfg_valid/cfg_ready write channel;
// cfg_ready stays low while requests or results are in flight.
// Once initialized, throughput is one byte per cycle while the result queue
// has room, set by the 16-step unrolled feedback network. The first request
// after reset or finish starts initialization (load, mixing, accumulator and
// shift register phases); a result then shows the cycle after it is taken.
// Reset clears all control state and the configuration registers.
// A stalled result side backs up the two-entry result queue, then the
// two-entry request queue, then raises full.
// ----------------------------------------------------------------------------
`default_nettype none
module grain128_aead_byte_engine (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [7:0]  data_byte_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_byte_o,
  output logic [63:0]      tag_o,
  output logic             is_tag_o,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i
);

  logic [63:0]    key_low_q, key_high_q, nonce_low_q;
  logic [31:0]    nonce_high_q;
  logic           decrypt_q;
  logic           cmd_valid, cmd_take, busy;
  g128_pkg::cmd_t cmd;

  assign cfg_ready = !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q    <= '0;
      key_high_q   <= '0;
      nonce_low_q  <= '0;
      nonce_high_q <= '0;
      decrypt_q    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_i)
        g128_pkg::CFG_KEY_LOW:    key_low_q    <= cfg_data_i;
        g128_pkg::CFG_KEY_HIGH:   key_high_q   <= cfg_data_i;
        g128_pkg::CFG_NONCE_LOW:  nonce_low_q  <= cfg_data_i;
        g128_pkg::CFG_NONCE_HIGH: nonce_high_q <= cfg_data_i[31:0];
        g128_pkg::CFG_DECRYPT:    decrypt_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  g128_front u_front (
    .clk_i, .rst_ni,
    .push_i      (push),
    .full_o      (full),
    .req_type_i,
    .data_byte_i,
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_take_i  (cmd_take)
  );

  g128_back u_back (
    .clk_i, .rst_ni,
    .key_low_i    (key_low_q),
    .key_high_i   (key_high_q),
    .nonce_low_i  (nonce_low_q),
    .nonce_high_i (nonce_high_q),
    .decrypt_i    (decrypt_q),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_take_o   (cmd_take),
    .busy_o       (busy),
    .empty_o      (empty),
    .pop_i        (pop),
    .out_byte_o,
    .tag_o,
    .is_tag_o
  );

endmodule
`default_nettype wire

>>> design/g128_front.sv
// ----------------------------------------------------------------------------
// g128_front
// Input side: accept requests, drop unused codes, queue the rest.
// ----------------------------------------------------------------------------
`default_nettype none
module g128_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  output logic                 full_o,
  input  wire logic [1:0]      req_type_i,
  input  wire logic [7:0]      data_byte_i,
  output logic                 cmd_valid_o,
  output g128_pkg::cmd_t       cmd_o,
  input  wire logic            cmd_take_i
);

  g128_pkg::cmd_t slot_q [2];
  logic           wr_q, wr_d, rd_q, rd_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           push_ok;
  logic           keep;

  assign full_o      = (cnt_q == 2'd2);
  assign push_ok     = push_i && !full_o;
  assign keep        = push_ok && (req_type_i != g128_pkg::REQ_NONE);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q ^ keep;
    rd_d  = rd_q ^ (cmd_take_i && cmd_valid_o);
    cnt_d = cnt_q + {1'b0, keep} - {1'b0, cmd_take_i && cmd_valid_o};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (keep) begin
      slot_q[wr_q] <= '{req: g128_pkg::req_e'(req_type_i), data: data_byte_i};
    end
  end

endmodule
`default_nettype wire

>>> design/g128_back.sv
// ----------------------------------------------------------------------------
// g128_back
// Cipher core: initialization sequencer, 16 cipher steps per byte, output queue.
// ----------------------------------------------------------------------------
`default_nettype none
module g128_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [63:0]     key_low_i,
  input  wire logic [63:0]     key_high_i,
  input  wire logic [63:0]     nonce_low_i,
  input  wire logic [31:0]     nonce_high_i,
  input  wire logic            decrypt_i,
  input  wire logic            cmd_valid_i,
  input  wire g128_pkg::cmd_t  cmd_i,
  output logic                 cmd_take_o,
  output logic                 busy_o,
  output logic                 empty_o,
  input  wire logic            pop_i,
  output logic [7:0]           out_byte_o,
  output logic [63:0]          tag_o,
  output logic                 is_tag_o
);

  g128_pkg::phase_e           ph_q, ph_d;
  logic [g128_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic                       init_q, init_d;
  g128_pkg::cipher_t          st_q, st_d;
  logic [63:0]                acc_q, acc_d, sr_q, sr_d;
  g128_pkg::step_t            stp;
  logic                       feed;
  logic [15:0]                extra;
  logic [7:0]                 ob;
  logic                       pbit;

  // two-entry result queue
  logic [72:0]                res_q [2];
  logic                       rw_q, rr_q;
  logic [1:0]                 rc_q;
  logic                       res_push, res_pop;
  logic [72:0]                res_d;

  assign res_pop  = pop_i && (rc_q != 2'd0);
  assign empty_o  = (rc_q == 2'd0);
  assign {is_tag_o, tag_o, out_byte_o} = res_q[rr_q];
  assign busy_o   = (ph_q != g128_pkg::PH_IDLE) || cmd_valid_i || (rc_q != 2'd0);

  always_comb begin
    feed  = (ph_q == g128_pkg::PH_MIX);
    unique case (ph_q)
      g128_pkg::PH_ACC: extra = key_low_i[cnt_q[1:0]*16 +: 16];
      g128_pkg::PH_SR:  extra = key_high_i[cnt_q[1:0]*16 +: 16];
      default:          extra = '0;
    endcase
  end

  assign stp = g128_pkg::grain_step16(st_q, feed, extra);

  always_comb begin
    ph_d       = ph_q;
    cnt_d      = cnt_q;
    init_d     = init_q;
    st_d       = st_q;
    acc_d      = acc_q;
    sr_d       = sr_q;
    cmd_take_o = 1'b0;
    res_push   = 1'b0;
    res_d      = '0;
    ob         = '0;
    pbit       = 1'b0;
    unique case (ph_q)
      g128_pkg::PH_IDLE: begin
        if (cmd_valid_i && !init_q) begin
          st_d.nfsr = {key_high_i, key_low_i};
          st_d.lfsr = {1'b0, 31'h7fffffff, nonce_high_i, nonce_low_i};
          ph_d      = g128_pkg::PH_MIX;
          cnt_d     = '0;
        end else if (cmd_valid_i && (rc_q != 2'd2 || res_pop)) begin
          cmd_take_o = 1'b1;
          if (cmd_i.req == g128_pkg::REQ_FINISH) begin
            res_push = 1'b1;
            res_d    = {1'b1, acc_q ^ sr_q, 8'h00};
            init_d   = 1'b0;
          end else begin
            st_d = stp.st;
            for (int i = 0; i < 8; i++) begin
              ob[i] = cmd_i.data[i] ^ stp.y[2*i];
              pbit  = (cmd_i.req == g128_pkg::REQ_MSG && decrypt_i) ? ob[i]
                                                                   : cmd_i.data[i];
              if (pbit) acc_d = acc_d ^ sr_d;
              sr_d = {stp.y[2*i+1], sr_d[63:1]};
            end
            if (cmd_i.req == g128_pkg::REQ_MSG) begin
              res_push = 1'b1;
              res_d    = {1'b0, 64'h0, ob};
            end
          end
        end
      end
      g128_pkg::PH_MIX: begin
        st_d  = stp.st;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == g128_pkg::CntW'(g128_pkg::MixCycles - 1)) begin
          ph_d  = g128_pkg::PH_ACC;
          cnt_d = '0;
        end
      end
      g128_pkg::PH_ACC: begin
        st_d = stp.st;
        acc_d[cnt_q[1:0]*16 +: 16] = stp.y;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == g128_pkg::CntW'(g128_pkg::LoadCycles - 1)) begin
          ph_d  = g128_pkg::PH_SR;
          cnt_d = '0;
        end
      end
      g128_pkg::PH_SR: begin
        st_d = stp.st;
        sr_d[cnt_q[1:0]*16 +: 16] = stp.y;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == g128_pkg::CntW'(g128_pkg::LoadCycles - 1)) begin
          ph_d   = g128_pkg::PH_IDLE;
          cnt_d  = '0;
          init_d = 1'b1;
        end
      end
      default: ph_d = g128_pkg::PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= g128_pkg::PH_IDLE;
      cnt_q  <= '0;
      init_q <= 1'b0;
      rw_q   <= 1'b0;
      rr_q   <= 1'b0;
      rc_q   <= 2'd0;
    end else begin
      ph_q   <= ph_d;
      cnt_q  <= cnt_d;
      init_q <= init_d;
      rw_q   <= rw_q ^ res_push;
      rr_q   <= rr_q ^ res_pop;
      rc_q   <= rc_q + {1'b0, res_push} - {1'b0, res_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    st_q  <= st_d;
    acc_q <= acc_d;
    sr_q  <= sr_d;
    if (res_push) begin
      res_q[rw_q] <= res_d;
    end
  end

endmodule
`default_nettype wire

>>> design/g128_checker.sv
// ----------------------------------------------------------------------------
// g128_checker
// Port-level checks on the engine, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module g128_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic        is_tag_o,
  input wire logic [7:0]  out_byte_o,
  input wire logic [63:0] tag_o
);

  logic [72:0] res_w;

  assign res_w = {is_tag_o, tag_o, out_byte_o};

  `ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> (empty && !full), "queues busy after reset")
  `ASSERT_CLK(a_hold, clk_i, rst_ni, (!empty && !pop) |=> $stable(res_w), "waiting result changed")
  `ASSERT_CLK(a_tag_byte, clk_i, rst_ni, (!empty && is_tag_o) |-> (out_byte_o == 8'h00), "tag byte")
  `ASSERT_CLK(a_msg_tag, clk_i, rst_ni, (!empty && !is_tag_o) |-> (tag_o == 64'h0), "byte tag")

endmodule

bind grain128_aead_byte_engine g128_checker u_chk (
  .clk_i, .rst_ni, .full, .empty, .pop, .is_tag_o, .out_byte_o, .tag_o
);
`default_nettype wire
